>>> hw/rtl/wfba_pkg.sv
// wfba_pkg: shared constants, request codes, controller states and the
// command and status structs between the controller and the datapath
// no dependencies
package wfba_pkg;

   localparam int MAX_BLOCKS    = 16;
   localparam int SIZE_WIDTH    = 16;
   localparam int IDX_WIDTH     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_WIDTH     = $clog2(MAX_BLOCKS + 1);
   localparam int ACTIVE_WIDTH  = 5;
   localparam int TYPE_WIDTH    = 1;
   localparam int BLKNUM_WIDTH  = 4;
   localparam int LEFTOVER_WIDTH = 16;
   localparam int SIZEIN_WIDTH  = 16;
   localparam int SPAN_WIDTH    = (CNT_WIDTH > ACTIVE_WIDTH) ? CNT_WIDTH : ACTIVE_WIDTH;

   typedef enum logic [TYPE_WIDTH-1:0] {
      REQ_LOAD  = 1'b0,
      REQ_ALLOC = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_COMMIT,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic start;
      logic step;
      logic commit;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic span_zero;
      logic scan_last;
      logic out_free;
   } dp_sts_type;

endpackage

>>> hw/rtl/wfba_ctrl.sv
// wfba_ctrl: sequencer that accepts a word, steps the table scan and hands
// the result to the output register
// depends on wfba_pkg
module wfba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                csr_ready,
   input  wfba_pkg::dp_sts_type sts,
   output wfba_pkg::dp_cmd_type cmd
);
   import wfba_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      csr_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            csr_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               cmd.start   = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            priority if (!sts.is_alloc) begin
               cmd.commit = 1'b1;
               state_in   = ST_EMIT;
            end else if (sts.span_zero) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // scan only runs over a nonempty span
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !sts.span_zero)
      else $error("scan entered with empty span");

   // an accepted word always leads to dispatch next
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DISPATCH))
      else $error("accepted word not dispatched");

   // a load never scans
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DISPATCH && !sts.is_alloc) |=> (state_ff == ST_EMIT))
      else $error("load took the scan path");

endmodule

>>> hw/rtl/wfba_dpath.sv
// wfba_dpath: free size table, item registers, worst-fit scan registers
// and the result register
// depends on wfba_pkg
module wfba_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wfba_pkg::dp_cmd_type                  cmd,
   output wfba_pkg::dp_sts_type                  sts,
   input  logic                                  csr_we,
   input  logic [wfba_pkg::ACTIVE_WIDTH-1:0]     csr_data,
   input  logic [wfba_pkg::TYPE_WIDTH-1:0]       in_type,
   input  logic [wfba_pkg::BLKNUM_WIDTH-1:0]     in_index,
   input  logic [wfba_pkg::SIZEIN_WIDTH-1:0]     in_size,
   input  logic                                  out_stall,
   output logic                                  out_valid,
   output logic                                  out_granted,
   output logic [wfba_pkg::BLKNUM_WIDTH-1:0]     out_number,
   output logic [wfba_pkg::LEFTOVER_WIDTH-1:0]   out_leftover
);
   import wfba_pkg::*;

   logic [ACTIVE_WIDTH-1:0]  active_ff;
   logic [MAX_BLOCKS-1:0]    tbl_vld_ff;
   logic [SIZE_WIDTH-1:0]    tbl_data_ff [MAX_BLOCKS];

   req_kind_type             item_kind_ff;
   logic [BLKNUM_WIDTH-1:0]  item_idx_ff;
   logic [SIZE_WIDTH-1:0]    item_size_ff;

   logic [IDX_WIDTH-1:0]     scan_idx_ff;
   logic [CNT_WIDTH-1:0]     span_ff;
   logic [IDX_WIDTH-1:0]     best_idx_ff;
   logic [SIZE_WIDTH-1:0]    best_size_ff;
   logic                     found_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_granted_ff;
   logic [BLKNUM_WIDTH-1:0]  rsp_number_ff;
   logic [LEFTOVER_WIDTH-1:0] rsp_leftover_ff;

   logic [SIZE_WIDTH-1:0]    rd_size;
   logic                     rd_better;
   logic [CNT_WIDTH-1:0]     span_in;
   logic [SIZE_WIDTH-1:0]    remain;
   logic [IDX_WIDTH-1:0]     load_addr;
   logic                     load_in_range;
   logic                     out_free;

   always_comb begin
      if (SPAN_WIDTH'(active_ff) > SPAN_WIDTH'(MAX_BLOCKS)) begin
         span_in = CNT_WIDTH'(MAX_BLOCKS);
      end else begin
         span_in = CNT_WIDTH'(active_ff);
      end
   end

   assign rd_size   = tbl_vld_ff[scan_idx_ff] ? tbl_data_ff[scan_idx_ff] : '0;
   assign rd_better = (rd_size >= item_size_ff) && (!found_ff || (rd_size > best_size_ff));
   assign remain    = best_size_ff - item_size_ff;
   assign load_addr = IDX_WIDTH'(item_idx_ff);
   assign load_in_range = (32'(item_idx_ff) < MAX_BLOCKS);
   assign out_free  = !rsp_valid_ff || !out_stall;

   assign sts.is_alloc  = (item_kind_ff == REQ_ALLOC);
   assign sts.span_zero = (span_ff == '0);
   assign sts.scan_last = ((CNT_WIDTH'(scan_idx_ff) + 1'b1) == span_ff);
   assign sts.out_free  = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (csr_we) begin
         active_ff <= csr_data;
      end
   end

   // valid bits give the all-zero reset view of the table
   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_vld_ff <= '0;
      end else if (cmd.commit) begin
         if (item_kind_ff == REQ_LOAD) begin
            if (load_in_range) begin
               tbl_vld_ff[load_addr] <= 1'b1;
            end
         end else if (found_ff) begin
            tbl_vld_ff[best_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (item_kind_ff == REQ_LOAD) begin
            if (load_in_range) begin
               tbl_data_ff[load_addr] <= item_size_ff;
            end
         end else if (found_ff) begin
            tbl_data_ff[best_idx_ff] <= remain;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_kind_ff <= req_kind_type'(in_type);
         item_idx_ff  <= in_index;
         item_size_ff <= SIZE_WIDTH'(in_size);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff    <= 1'b0;
         scan_idx_ff <= '0;
         span_ff     <= '0;
      end else if (cmd.start) begin
         found_ff    <= 1'b0;
         scan_idx_ff <= '0;
         span_ff     <= span_in;
      end else if (cmd.step) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
         if (rd_better) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && rd_better) begin
         best_idx_ff  <= scan_idx_ff;
         best_size_ff <= rd_size;
      end else if (cmd.commit && item_kind_ff == REQ_ALLOC && found_ff) begin
         best_size_ff <= remain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!out_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (item_kind_ff == REQ_LOAD) begin
            rsp_granted_ff  <= 1'b0;
            rsp_number_ff   <= item_idx_ff;
            rsp_leftover_ff <= load_in_range ? LEFTOVER_WIDTH'(item_size_ff) : '0;
         end else if (found_ff) begin
            rsp_granted_ff  <= 1'b1;
            rsp_number_ff   <= BLKNUM_WIDTH'(best_idx_ff);
            rsp_leftover_ff <= LEFTOVER_WIDTH'(best_size_ff);
         end else begin
            rsp_granted_ff  <= 1'b0;
            rsp_number_ff   <= '0;
            rsp_leftover_ff <= '0;
         end
      end
   end

   assign out_valid    = rsp_valid_ff;
   assign out_granted  = rsp_granted_ff;
   assign out_number   = rsp_number_ff;
   assign out_leftover = rsp_leftover_ff;

   // the result register is never overwritten while a word waits in it
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result register overwritten");

   // the scan pointer stays inside the active span
   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (CNT_WIDTH'(scan_idx_ff) < span_ff))
      else $error("scan pointer beyond span");

   // a granted block holds the reduced size after the update
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && item_kind_ff == REQ_ALLOC && found_ff) |=>
      (tbl_vld_ff[best_idx_ff] && tbl_data_ff[best_idx_ff] == best_size_ff))
      else $error("table update mismatch");

   // the best candidate always satisfies the request
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && item_kind_ff == REQ_ALLOC && found_ff) |->
      (best_size_ff >= item_size_ff))
      else $error("chosen block too small");

endmodule

>>> hw/rtl/worst_fit_block_allocator_core.sv
// worst_fit_block_allocator_core: top level of the worst-fit block allocator
// depends on wfba_pkg, wfba_ctrl, wfba_dpath
//
//   channel  handshake           word
//   req      req_valid/stall     req_type, req_block_index, req_size_value
//   rsp      rsp_valid/stall     rsp_granted, rsp_block_number, rsp_leftover
//   csr      csr_valid/ready     csr_active_blocks
//
// load word: accept, dispatch and emit, then the result register
// allocate word: dispatch, a scan over n = active blocks (max 16), commit and emit; no scan when n is 0
// one word in flight; req_stall is low only while the sequencer is idle
// a finished result waits in the output register while the next word is taken
// synchronous reset clears the table view, active_blocks and all control state
module worst_fit_block_allocator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [wfba_pkg::TYPE_WIDTH-1:0]     req_type,
   input  logic [wfba_pkg::BLKNUM_WIDTH-1:0]   req_block_index,
   input  logic [wfba_pkg::SIZEIN_WIDTH-1:0]   req_size_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_granted,
   output logic [wfba_pkg::BLKNUM_WIDTH-1:0]   rsp_block_number,
   output logic [wfba_pkg::LEFTOVER_WIDTH-1:0] rsp_leftover,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wfba_pkg::ACTIVE_WIDTH-1:0]   csr_active_blocks
);
   import wfba_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   wfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_ready (csr_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   wfba_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .csr_we       (csr_valid && csr_ready),
      .csr_data     (csr_active_blocks),
      .in_type      (req_type),
      .in_index     (req_block_index),
      .in_size      (req_size_value),
      .out_stall    (rsp_stall),
      .out_valid    (rsp_valid),
      .out_granted  (rsp_granted),
      .out_number   (rsp_block_number),
      .out_leftover (rsp_leftover)
   );

endmodule

>>> tb/tb_worst_fit_block_allocator_core.sv
// tb_worst_fit_block_allocator_core: self-checking testbench for the worst-fit block allocator
// drives a directed table, then random phases under idle, stall and back-pressure patterns
// depends on wfba_pkg and worst_fit_block_allocator_core
`timescale 1ns / 1ps

module tb_worst_fit_block_allocator_core;

   import wfba_pkg::*;

   typedef struct packed {
      logic                      granted;
      logic [BLKNUM_WIDTH-1:0]   block_number;
      logic [LEFTOVER_WIDTH-1:0] leftover;
   } alloc_result_type;

   typedef struct packed {
      logic                     set_span;
      logic [ACTIVE_WIDTH-1:0]  span;
      req_kind_type             kind;
      logic [BLKNUM_WIDTH-1:0]  index;
      logic [SIZEIN_WIDTH-1:0]  size;
      logic                     typed;
      alloc_result_type         want;
   } directed_row_type;

   localparam int N_DIRECTED = 20;
   localparam int N_PHASES   = 8;
   localparam int HOLD_CYCLES = 400;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [TYPE_WIDTH-1:0]     req_type = '0;
   logic [BLKNUM_WIDTH-1:0]   req_block_index = '0;
   logic [SIZEIN_WIDTH-1:0]   req_size_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_granted;
   logic [BLKNUM_WIDTH-1:0]   rsp_block_number;
   logic [LEFTOVER_WIDTH-1:0] rsp_leftover;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [ACTIVE_WIDTH-1:0]   csr_active_blocks = '0;

   // side band that travels with the request word
   logic             word_typed = 1'b0;
   alloc_result_type word_want = '0;

   logic          hold_start = 1'b0;
   int            hold_left = 0;
   int            send_gap_pct = 0;
   int            rsp_stall_pct = 0;

   logic [SIZE_WIDTH-1:0]   free_tab [MAX_BLOCKS];
   logic [ACTIVE_WIDTH-1:0] span_cfg = '0;
   alloc_result_type        pending_results [$];
   int                      errors = 0;
   int                      cur_span = 0;

   directed_row_type directed_rows [N_DIRECTED];

   worst_fit_block_allocator_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_block_index  (req_block_index),
      .req_size_value   (req_size_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted      (rsp_granted),
      .rsp_block_number (rsp_block_number),
      .rsp_leftover     (rsp_leftover),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_active_blocks(csr_active_blocks)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #8_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // load writes the model table; allocate takes the worst-fit choice over the active entries, lowest index on a tie
   function automatic alloc_result_type predict_alloc(req_kind_type kind,
                                                      logic [BLKNUM_WIDTH-1:0] index,
                                                      logic [SIZEIN_WIDTH-1:0] size);
      alloc_result_type r;
      int               n;
      int               best;
      bit               found;
      r = '0;
      best = 0;
      found = 1'b0;
      n = (span_cfg > MAX_BLOCKS) ? MAX_BLOCKS : int'(span_cfg);
      if (kind == REQ_LOAD) begin
         r.block_number = index;
         if (index < MAX_BLOCKS) begin
            free_tab[index] = size;
            r.leftover = size;
         end
      end else begin
         for (int j = 0; j < n; j++) begin
            if (free_tab[j] >= size && (!found || free_tab[j] > free_tab[best])) begin
               best = j;
               found = 1'b1;
            end
         end
         if (found) begin
            free_tab[best] = free_tab[best] - size;
            r.granted = 1'b1;
            r.block_number = best[BLKNUM_WIDTH-1:0];
            r.leftover = free_tab[best];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type w;
      alloc_result_type got;
      if (reset) begin
         for (int j = 0; j < MAX_BLOCKS; j++) free_tab[j] = '0;
         span_cfg = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_granted, rsp_block_number, rsp_leftover};
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected word granted %0h block_number %0h leftover %0h",
                        $time, got.granted, got.block_number, got.leftover);
               errors++;
            end else begin
               w = pending_results.pop_front();
               if (got.granted !== w.granted) begin
                  $display("%0t: rsp_granted expected %0h actual %0h",
                           $time, w.granted, got.granted);
                  errors++;
               end
               if (got.block_number !== w.block_number) begin
                  $display("%0t: rsp_block_number expected %0h actual %0h",
                           $time, w.block_number, got.block_number);
                  errors++;
               end
               if (got.leftover !== w.leftover) begin
                  $display("%0t: rsp_leftover expected %0h actual %0h",
                           $time, w.leftover, got.leftover);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) span_cfg = csr_active_blocks;
         if (req_valid && !req_stall) begin
            w = predict_alloc(req_kind_type'(req_type), req_block_index, req_size_value);
            pending_results.push_back(word_typed ? word_want : w);
         end
      end
   end

   // receiver: random stall, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   task automatic send_word(input req_kind_type kind, input logic [BLKNUM_WIDTH-1:0] index,
                            input logic [SIZEIN_WIDTH-1:0] size, input logic typed,
                            input alloc_result_type want);
      if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_gap_pct);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_block_index <= index;
      req_size_value  <= size;
      word_typed      <= typed;
      word_want       <= want;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_span(input logic [ACTIVE_WIDTH-1:0] value);
      wait_drained();
      csr_valid         <= 1'b1;
      csr_active_blocks <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_span = (value > MAX_BLOCKS) ? MAX_BLOCKS : int'(value);
   endtask

   function automatic logic [SIZEIN_WIDTH-1:0] random_size();
      unique case ($urandom_range(0, 3))
         0: return SIZEIN_WIDTH'($urandom_range(0, 16'hFFFF));
         1: return SIZEIN_WIDTH'($urandom_range(0, 255));
         2: return 16'hFFFF;
         default: return SIZEIN_WIDTH'($urandom_range(16'h8000, 16'hFFFF));
      endcase
   endfunction

   task automatic send_random_word();
      req_kind_type            kind;
      logic [BLKNUM_WIDTH-1:0] index;
      logic [SIZEIN_WIDTH-1:0] size;
      int                      r;
      int                      j;
      r = $urandom_range(0, 99);
      index = BLKNUM_WIDTH'($urandom_range(0, MAX_BLOCKS - 1));
      j = (cur_span == 0) ? 0 : $urandom_range(0, cur_span - 1);
      if (r < 8) begin
         kind = req_kind_type'($urandom_range(0, 1));
         size = SIZEIN_WIDTH'($urandom_range(0, 16'hFFFF));
      end else if (r < 32) begin
         kind = REQ_LOAD;
         if (cur_span != 0 && $urandom_range(0, 3) != 0) index = BLKNUM_WIDTH'(j);
         size = random_size();
      end else begin
         kind = REQ_ALLOC;
         r = $urandom_range(0, 99);
         if (r < 15) size = '0;
         else if (r < 25) size = SIZEIN_WIDTH'($urandom_range(0, 16'hFFFF));
         else if (r < 75) size = SIZEIN_WIDTH'($urandom_range(0, free_tab[j]));
         else if (r < 90) size = free_tab[j];
         else size = free_tab[j] + 1'b1;
      end
      send_word(kind, index, size, 1'b0, '0);
   endtask

   initial begin
      int                      spans [N_PHASES];
      int                      counts [N_PHASES];
      int                      sent;

      directed_rows = '{
         // nothing active after reset
         '{1'b0, 5'd0,  REQ_ALLOC, 4'd0,  16'h0000, 1'b1, '{1'b0, 4'd0,  16'h0000}},
         '{1'b0, 5'd0,  REQ_LOAD,  4'd0,  16'hFFFF, 1'b1, '{1'b0, 4'd0,  16'hFFFF}},
         '{1'b0, 5'd0,  REQ_LOAD,  4'd15, 16'h0000, 1'b1, '{1'b0, 4'd15, 16'h0000}},
         '{1'b0, 5'd0,  REQ_ALLOC, 4'd15, 16'h0001, 1'b1, '{1'b0, 4'd0,  16'h0000}},
         // full table, ties and exact fits
         '{1'b1, 5'd16, REQ_LOAD,  4'd15, 16'hFFFF, 1'b1, '{1'b0, 4'd15, 16'hFFFF}},
         '{1'b0, 5'd16, REQ_LOAD,  4'd7,  16'h8000, 1'b1, '{1'b0, 4'd7,  16'h8000}},
         '{1'b0, 5'd16, REQ_ALLOC, 4'd9,  16'h0000, 1'b1, '{1'b1, 4'd0,  16'hFFFF}},
         '{1'b0, 5'd16, REQ_ALLOC, 4'd0,  16'hFFFF, 1'b1, '{1'b1, 4'd0,  16'h0000}},
         '{1'b0, 5'd16, REQ_ALLOC, 4'd0,  16'hFFFF, 1'b1, '{1'b1, 4'd15, 16'h0000}},
         '{1'b0, 5'd16, REQ_ALLOC, 4'd0,  16'h8001, 1'b1, '{1'b0, 4'd0,  16'h0000}},
         '{1'b0, 5'd16, REQ_ALLOC, 4'd0,  16'h8000, 1'b1, '{1'b1, 4'd7,  16'h0000}},
         '{1'b0, 5'd16, REQ_LOAD,  4'd3,  16'h5555, 1'b0, '0},
         '{1'b0, 5'd16, REQ_LOAD,  4'd4,  16'hAAAA, 1'b0, '0},
         '{1'b0, 5'd16, REQ_ALLOC, 4'd10, 16'h1234, 1'b0, '0},
         // active count above the table size
         '{1'b1, 5'd31, REQ_ALLOC, 4'd5,  16'h0001, 1'b0, '0},
         '{1'b0, 5'd31, REQ_LOAD,  4'd9,  16'h00FF, 1'b0, '0},
         // only block 0 active
         '{1'b1, 5'd1,  REQ_LOAD,  4'd0,  16'h0064, 1'b1, '{1'b0, 4'd0,  16'h0064}},
         '{1'b0, 5'd1,  REQ_ALLOC, 4'd0,  16'h0064, 1'b1, '{1'b1, 4'd0,  16'h0000}},
         '{1'b0, 5'd1,  REQ_ALLOC, 4'd0,  16'h0001, 1'b1, '{1'b0, 4'd0,  16'h0000}},
         '{1'b0, 5'd1,  REQ_ALLOC, 4'd15, 16'h0000, 1'b1, '{1'b1, 4'd0,  16'h0000}}
      };
      spans  = '{16, 16, 31, 1, 2, 0, 0, 16};
      counts = '{260, 260, 260, 200, 260, 40, 300, 300};
      spans[6] = $urandom_range(3, 15);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_span) write_span(directed_rows[i].span);
         send_word(directed_rows[i].kind, directed_rows[i].index, directed_rows[i].size,
                   directed_rows[i].typed, directed_rows[i].want);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         write_span(ACTIVE_WIDTH'(spans[p]));
         unique case (p % 4)
            0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_gap_pct = 55; rsp_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct = 55; end
            default: begin send_gap_pct = 17; rsp_stall_pct = 17; end
         endcase
         if (p == 4) begin
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         sent = 0;
         // fill the active blocks first so allocations have room to land
         for (int j = 0; j < cur_span && sent < counts[p]; j++) begin
            send_word(REQ_LOAD, BLKNUM_WIDTH'(j), random_size(), 1'b0, '0);
            sent++;
         end
         while (sent < counts[p]) begin
            if (p == 4 && sent == counts[p] / 2) wait_drained();
            send_random_word();
            sent++;
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d words never arrived", $time, pending_results.size());
         errors++;
      end
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
